/* sv/fmt_pkg.sv */
package fmt_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 64;

    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam logic [63:0] ONE_LO   = 64'h0000_0000_3F80_0000;
    localparam logic [63:0] ONE_HI   = 64'h3F80_0000_0000_0000;

    // Pipeline depth: multiply, then two adder levels, three stages each
    localparam int MUL_LAT = 3;
    localparam int ADD_LAT = 3;
    localparam int PIPE_LAT = MUL_LAT + 2 * ADD_LAT;

    typedef struct packed {
        logic [31:0] in_row0;
        logic [31:0] in_row1;
        logic [31:0] in_row2;
        logic [31:0] in_row3;
        logic        batch_end_in;
    } t_vec_in;

    typedef struct packed {
        logic [31:0] out_row0;
        logic [31:0] out_row1;
        logic [31:0] out_row2;
        logic [31:0] out_row3;
        logic        batch_end_out;
    } t_vec_out;

    // Leading zero count of a 48-bit word (48 when zero)
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] cnt;
        cnt = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                cnt = 6'(47 - i);
            end
        end
        return cnt;
    endfunction

    // Leading zero count of a 27-bit word (27 when zero)
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] cnt;
        cnt = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                cnt = 5'(26 - i);
            end
        end
        return cnt;
    endfunction

endpackage

/* sv/fmt_fmul.sv */
module fmt_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    // stage A: unpack, classify, integer multiply
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [23:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zro_a, zro_b;
    logic [9:0]  eea, eeb;

    logic [47:0]        r_a_prod;
    logic signed [10:0] r_a_exp;
    logic               r_a_sign, r_a_nan, r_a_inf;

    always_comb begin
        ea = i_a[30:23];
        eb = i_b[30:23];
        fa = i_a[22:0];
        fb = i_b[22:0];
        ma = {|ea, fa};
        mb = {|eb, fb};
        eea = (ea == 8'd0) ? 10'd1 : {2'b0, ea};
        eeb = (eb == 8'd0) ? 10'd1 : {2'b0, eb};
        nan_a = (ea == 8'hFF) && (fa != 23'd0);
        nan_b = (eb == 8'hFF) && (fb != 23'd0);
        inf_a = (ea == 8'hFF) && (fa == 23'd0);
        inf_b = (eb == 8'hFF) && (fb == 23'd0);
        zro_a = (ea == 8'd0) && (fa == 23'd0);
        zro_b = (eb == 8'd0) && (fb == 23'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_prod <= ma * mb;
            r_a_exp  <= signed'({1'b0, eea}) + signed'({1'b0, eeb}) - 11'sd126;
            r_a_sign <= i_a[31] ^ i_b[31];
            r_a_nan  <= nan_a | nan_b | (inf_a & zro_b) | (inf_b & zro_a);
            r_a_inf  <= inf_a | inf_b;
        end
    end

    // stage B: leading zeros, pick shift direction and amount
    logic [5:0]         lz;
    logic signed [10:0] dexp;
    logic               n_left, n_ovf;
    logic [5:0]         n_sh;
    logic [7:0]         n_be;

    logic [47:0] r_b_prod;
    logic        r_b_left, r_b_ovf, r_b_sign, r_b_nan, r_b_inf;
    logic [5:0]  r_b_sh;
    logic [7:0]  r_b_be;

    always_comb begin
        lz     = fmt_pkg::lzc48(r_a_prod);
        dexp   = r_a_exp - signed'({5'b0, lz});
        n_left = 1'b1;
        n_ovf  = 1'b0;
        n_sh   = lz;
        n_be   = 8'd0;
        if (dexp >= 11'sd1) begin
            n_be  = dexp[7:0];
            n_ovf = (dexp >= 11'sd255);
        end else if (r_a_exp >= 11'sd1) begin
            // subnormal result, stop shifting at the minimum exponent
            n_sh = 6'(r_a_exp - 11'sd1);
        end else begin
            n_left = 1'b0;
            n_sh   = (r_a_exp <= -11'sd62) ? 6'd63 : 6'(11'sd1 - r_a_exp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_prod <= r_a_prod;
            r_b_left <= n_left;
            r_b_ovf  <= n_ovf;
            r_b_sh   <= n_sh;
            r_b_be   <= n_be;
            r_b_sign <= r_a_sign;
            r_b_nan  <= r_a_nan;
            r_b_inf  <= r_a_inf & ~r_a_nan;
        end
    end

    // stage C: shift, round to nearest even, pack
    logic [47:0] nrm;
    logic        st_out, rnd;
    logic [30:0] mag;
    logic [31:0] n_y;
    logic [31:0] r_y;

    always_comb begin
        if (r_b_left) begin
            nrm    = r_b_prod << r_b_sh;
            st_out = 1'b0;
        end else begin
            nrm    = r_b_prod >> r_b_sh;
            st_out = |(r_b_prod & ~({48{1'b1}} << r_b_sh));
        end
        rnd = nrm[23] & ((|nrm[22:0]) | st_out | nrm[24]);
        mag = {r_b_be, nrm[46:24]} + {30'd0, rnd};
        if (r_b_nan) begin
            n_y = fmt_pkg::QNAN;
        end else if (r_b_inf || r_b_ovf) begin
            n_y = {r_b_sign, 8'hFF, 23'd0};
        end else if (r_b_prod == 48'd0) begin
            n_y = {r_b_sign, 31'd0};
        end else begin
            n_y = {r_b_sign, mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

/* sv/fmt_fadd.sv */
module fmt_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    // stage A: classify, order by magnitude, align the smaller operand
    logic [31:0] big, sml;
    logic [7:0]  eb_f, es_f, eb_e, es_e, d;
    logic [26:0] mbig, msml, shf;
    logic        nan_a, nan_b, inf_a, inf_b, sub, sticky;

    logic [26:0] r_a_mbig, r_a_msml;
    logic [7:0]  r_a_exp;
    logic        r_a_sub, r_a_sign, r_a_zsign, r_a_nan, r_a_inf, r_a_isign;

    always_comb begin
        if (i_a[30:0] >= i_b[30:0]) begin
            big = i_a;
            sml = i_b;
        end else begin
            big = i_b;
            sml = i_a;
        end
        eb_f = big[30:23];
        es_f = sml[30:23];
        eb_e = (eb_f == 8'd0) ? 8'd1 : eb_f;
        es_e = (es_f == 8'd0) ? 8'd1 : es_f;
        d    = eb_e - es_e;
        mbig = {|eb_f, big[22:0], 3'b000};
        msml = {|es_f, sml[22:0], 3'b000};
        if (d >= 8'd27) begin
            shf    = 27'd0;
            sticky = |msml;
        end else begin
            shf    = msml >> d;
            sticky = |(msml & ~({27{1'b1}} << d));
        end
        sub   = i_a[31] ^ i_b[31];
        nan_a = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        nan_b = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        inf_a = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        inf_b = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mbig  <= mbig;
            r_a_msml  <= {shf[26:1], shf[0] | sticky};
            r_a_exp   <= eb_e;
            r_a_sub   <= sub;
            r_a_sign  <= big[31];
            r_a_zsign <= i_a[31] & i_b[31];
            r_a_nan   <= nan_a | nan_b | (inf_a & inf_b & sub);
            r_a_inf   <= inf_a | inf_b;
            r_a_isign <= inf_a ? i_a[31] : i_b[31];
        end
    end

    // stage B: add or subtract magnitudes, count leading zeros
    logic [27:0] sum;

    logic [27:0] r_b_sum;
    logic [4:0]  r_b_lz;
    logic [7:0]  r_b_exp;
    logic        r_b_sign, r_b_zsign, r_b_nan, r_b_inf, r_b_isign;

    always_comb begin
        if (r_a_sub) begin
            sum = {1'b0, r_a_mbig} - {1'b0, r_a_msml};
        end else begin
            sum = {1'b0, r_a_mbig} + {1'b0, r_a_msml};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_sum   <= sum;
            r_b_lz    <= fmt_pkg::lzc27(sum[26:0]);
            r_b_exp   <= r_a_exp;
            r_b_sign  <= r_a_sign;
            r_b_zsign <= r_a_zsign;
            r_b_nan   <= r_a_nan;
            r_b_inf   <= r_a_inf & ~r_a_nan;
            r_b_isign <= r_a_isign;
        end
    end

    // stage C: normalize, round to nearest even, pack
    logic [26:0] nrm;
    logic [8:0]  e1;
    logic [7:0]  lim, sh, efld;
    logic        rnd;
    logic [30:0] mag;
    logic [31:0] n_y;
    logic [31:0] r_y;

    always_comb begin
        lim = r_b_exp - 8'd1;
        sh  = ({3'b0, r_b_lz} < lim) ? {3'b0, r_b_lz} : lim;
        if (r_b_sum[27]) begin
            nrm = {r_b_sum[27:2], r_b_sum[1] | r_b_sum[0]};
            e1  = {1'b0, r_b_exp} + 9'd1;
        end else begin
            nrm = r_b_sum[26:0] << sh;
            e1  = {1'b0, r_b_exp - sh};
        end
        efld = nrm[26] ? e1[7:0] : 8'd0;
        rnd  = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
        mag  = {efld, nrm[25:3]} + {30'd0, rnd};
        if (r_b_nan) begin
            n_y = fmt_pkg::QNAN;
        end else if (r_b_inf) begin
            n_y = {r_b_isign, 8'hFF, 23'd0};
        end else if (r_b_sum == 28'd0) begin
            n_y = {r_b_zsign, 31'd0};
        end else if (e1 >= 9'd255) begin
            n_y = {r_b_sign, 8'hFF, 23'd0};
        end else begin
            n_y = {r_b_sign, mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

/* sv/fixed_matrix_transform_4x4_fp32_top.sv */
// 4x4 single-precision matrix times column vector, one vector per cycle unless stalled.
// Input channel: i_in_valid / o_in_stall carry a request of four float32
// elements and a batch-end mark; the request is taken when valid is high
// and stall is low. Output channel: o_out_valid / i_out_stall carry the
// four result elements and the mark, taken the same way.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0..7
// selects a 64-bit register holding two matrix elements of one column;
// other indexes are ignored. Write it only while the pipe is empty.
// The pipe has three stages for the multiplies and three for each of
// the two adder levels. It takes one vector per cycle when not stalled;
// every stage register holds one request, so 9 requests can be in flight.
// Reset loads the identity matrix and empties the pipe.
// A stall on the output while a result waits freezes the whole pipe and
// raises o_in_stall in the same cycle; nothing is dropped or repeated.
// NaN results come out as 0x7FC00000; subnormals are kept.
module fixed_matrix_transform_4x4_fp32_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fmt_pkg::t_vec_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fmt_pkg::t_vec_out                   o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fmt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fmt_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    localparam int LAT = fmt_pkg::PIPE_LAT;

    logic en;
    logic [63:0] r_mreg [fmt_pkg::NUM_REGS];
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_be;
    logic [31:0] vin [4];
    logic [31:0] prod [4][4];
    logic [31:0] lo [4];
    logic [31:0] hi [4];
    logic [31:0] res [4];

    // whole pipe moves unless a waiting result is stalled
    assign en          = ~(r_vld[LAT-1] & i_out_stall);
    assign o_in_stall  = ~en;
    assign o_cfg_ready = 1'b1;

    // matrix registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mreg[0] <= fmt_pkg::ONE_LO;
            r_mreg[1] <= 64'd0;
            r_mreg[2] <= fmt_pkg::ONE_HI;
            r_mreg[3] <= 64'd0;
            r_mreg[4] <= 64'd0;
            r_mreg[5] <= fmt_pkg::ONE_LO;
            r_mreg[6] <= 64'd0;
            r_mreg[7] <= fmt_pkg::ONE_HI;
        end else if (i_cfg_valid && i_cfg_index < fmt_pkg::CFG_IDX_W'(fmt_pkg::NUM_REGS)) begin
            r_mreg[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // valid bits and batch-end mark ride alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_be <= {r_be[LAT-2:0], i_in_data.batch_end_in};
        end
    end

    assign vin[0] = i_in_data.in_row0;
    assign vin[1] = i_in_data.in_row1;
    assign vin[2] = i_in_data.in_row2;
    assign vin[3] = i_in_data.in_row3;

    // sixteen products, then a two-level add tree per row
    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            localparam int RI = c * 2 + r / 2;
            localparam int LO = (r % 2) * 32;
            fmt_fmul u_mul (
                .i_clk (i_clk),
                .i_en  (en),
                .i_a   (r_mreg[RI][LO +: 32]),
                .i_b   (vin[c]),
                .o_y   (prod[r][c])
            );
        end

        fmt_fadd u_add_lo (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (prod[r][0]),
            .i_b   (prod[r][1]),
            .o_y   (lo[r])
        );

        fmt_fadd u_add_hi (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (prod[r][2]),
            .i_b   (prod[r][3]),
            .o_y   (hi[r])
        );

        fmt_fadd u_add_out (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (lo[r]),
            .i_b   (hi[r]),
            .o_y   (res[r])
        );
    end

    assign o_out_valid              = r_vld[LAT-1];
    assign o_out_data.out_row0      = res[0];
    assign o_out_data.out_row1      = res[1];
    assign o_out_data.out_row2      = res[2];
    assign o_out_data.out_row3      = res[3];
    assign o_out_data.batch_end_out = r_be[LAT-1];

endmodule

/* test/fixed_matrix_transform_4x4_fp32_top_test.sv */
`timescale 1ns / 1ps

module fixed_matrix_transform_4x4_fp32_top_test;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    fmt_pkg::t_vec_in              i_in_data;
    logic                          o_out_valid;
    logic                          i_out_stall;
    fmt_pkg::t_vec_out             o_out_data;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [fmt_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [fmt_pkg::CFG_DAT_W-1:0] i_cfg_data;

    fixed_matrix_transform_4x4_fp32_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the matrix registers and the results still owed
    logic [63:0]       matrix_regs [fmt_pkg::NUM_REGS];
    fmt_pkg::t_vec_out pending_results [$];
    int                error_count;
    bit                stall_quiet;
    int                stall_hold;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Float32 helpers: exact widening to double, single RNE narrowing back
    function automatic logic [63:0] widen_f32(input logic [31:0] b);
        logic [63:0] d;
        logic [22:0] m;
        int          e;
        m = b[22:0];
        if (b[30:23] == 8'hFF) begin
            d = {b[31], 11'h7FF, m, 29'd0};
        end else if (b[30:23] != 8'd0) begin
            d = {b[31], 11'(b[30:23] + 896), m, 29'd0};
        end else if (m == 23'd0) begin
            d = {b[31], 63'd0};
        end else begin
            e = 897;
            while (!m[22]) begin
                m = m << 1;
                e = e - 1;
            end
            m = m << 1;
            e = e - 1;
            d = {b[31], 11'(e), m, 29'd0};
        end
        return d;
    endfunction

    function automatic logic [31:0] narrow_f64(input logic [63:0] d);
        logic [52:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] mag;
        int          e;
        int          sh;
        e = int'(d[62:52]);
        if (e == 2047) begin
            return (d[51:0] != 0) ? fmt_pkg::QNAN : {d[63], 8'hFF, 23'd0};
        end
        if (e == 0) begin
            return {d[63], 31'd0};
        end
        e = e - 1023;
        if (e > 127) begin
            return {d[63], 8'hFF, 23'd0};
        end
        sig = {1'b1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60) begin
            return {d[63], 31'd0};
        end
        q    = 64'(sig) >> sh;
        rem  = 64'(sig) & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 1;
        end
        // Hidden bit in q bumps the exponent by one, so the base is e+126
        if (e >= -126) begin
            q = q + (64'(e + 126) << 23);
        end
        if (q >= 64'h7F80_0000) begin
            mag = 32'h7F80_0000;
        end else begin
            mag = q[31:0];
        end
        return {d[63], mag[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        real x;
        real y;
        x = $bitstoreal(widen_f32(a));
        y = $bitstoreal(widen_f32(b));
        return narrow_f64($realtobits(x * y));
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        real x;
        real y;
        x = $bitstoreal(widen_f32(a));
        y = $bitstoreal(widen_f32(b));
        return narrow_f64($realtobits(x + y));
    endfunction

    function automatic logic [31:0] mat_elem(input int row, input int col);
        logic [63:0] r;
        r = matrix_regs[(col << 1) | (row >> 1)];
        return (row & 1) ? r[63:32] : r[31:0];
    endfunction

    // Expected transform of one vector
    function automatic fmt_pkg::t_vec_out transform_vec(input fmt_pkg::t_vec_in v);
        fmt_pkg::t_vec_out res;
        logic [31:0]       e [4];
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [31:0]       s;
        e[0] = v.in_row0;
        e[1] = v.in_row1;
        e[2] = v.in_row2;
        e[3] = v.in_row3;
        for (int r = 0; r < 4; r++) begin
            lo = fp_add(fp_mul(mat_elem(r, 0), e[0]), fp_mul(mat_elem(r, 1), e[1]));
            hi = fp_add(fp_mul(mat_elem(r, 2), e[2]), fp_mul(mat_elem(r, 3), e[3]));
            s  = fp_add(lo, hi);
            if (s[30:23] == 8'hFF && s[22:0] != 0) begin
                s = fmt_pkg::QNAN;
            end
            case (r)
                0: res.out_row0 = s;
                1: res.out_row1 = s;
                2: res.out_row2 = s;
                default: res.out_row3 = s;
            endcase
        end
        res.batch_end_out = v.batch_end_in;
        return res;
    endfunction

    // Random float32 with weight on special and awkward values
    function automatic logic [31:0] rand_f32();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 7))
                    0: b = 32'h0000_0000;
                    1: b = 32'h8000_0000;
                    2: b = 32'h7F80_0000;
                    3: b = 32'hFF80_0000;
                    4: b = {b[31], 8'hFF, b[22:1], 1'b1};
                    5: b = {b[31], 31'h7F7F_FFFF};
                    6: b = {b[31], 31'd1};
                    default: b = {b[31], 31'h3F80_0000};
                endcase
            end
            1: b[30:23] = 8'd0;
            2, 3, 4: b[30:23] = 8'($urandom_range(123, 131));
            5: ;
            6: b[30:23] = 8'($urandom_range(1, 8));
            7: b[30:23] = 8'($urandom_range(240, 254));
            default: b[30:23] = 8'($urandom_range(100, 154));
        endcase
        return b;
    endfunction

    function automatic logic [63:0] rand_reg();
        return {rand_f32(), rand_f32()};
    endfunction

    // Send one request; valid stays up across back-to-back requests
    task automatic send_vec(input fmt_pkg::t_vec_in v);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_results.push_back(transform_vec(v));
        case ($urandom_range(0, 19))
            0, 1, 2, 3: gap = $urandom_range(1, 3);
            4: gap = $urandom_range(10, 40);
            default: gap = 0;
        endcase
        if (stall_quiet) begin
            gap = 0;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_rand_vec();
        fmt_pkg::t_vec_in v;
        v.in_row0      = rand_f32();
        v.in_row1      = rand_f32();
        v.in_row2      = rand_f32();
        v.in_row3      = rand_f32();
        v.batch_end_in = ($urandom_range(0, 3) == 0);
        send_vec(v);
    endtask

    task automatic send_fill(input logic [31:0] a, input logic [31:0] b, input logic be);
        fmt_pkg::t_vec_in v;
        v.in_row0      = a;
        v.in_row1      = b;
        v.in_row2      = a;
        v.in_row3      = b;
        v.batch_end_in = be;
        send_vec(v);
    endtask

    // Register write only once the pipe has drained
    task automatic write_reg(input int idx, input logic [63:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (fmt_pkg::PIPE_LAT + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fmt_pkg::CFG_IDX_W'(idx);
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        if (idx < fmt_pkg::NUM_REGS) begin
            matrix_regs[idx] = val;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix_all(input logic [63:0] val);
        for (int i = 0; i < fmt_pkg::NUM_REGS; i++) begin
            write_reg(i, val);
        end
    endtask

    task automatic load_matrix_rand();
        for (int i = 0; i < fmt_pkg::NUM_REGS; i++) begin
            write_reg(i, rand_reg());
        end
    endtask

    // Identity after reset, driven with extreme and special values
    task automatic test_identity_extremes();
        fmt_pkg::t_vec_in v;
        send_fill(32'h0000_0000, 32'h8000_0000, 1'b0);
        send_fill(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_fill(32'h7F80_0000, 32'hFF80_0000, 1'b0);
        send_fill(32'h7FC0_0001, 32'hFFFF_FFFF, 1'b1);
        send_fill(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0);
        send_fill(32'h0000_0001, 32'h807F_FFFF, 1'b1);
        send_fill(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        v.in_row0      = 32'h3F80_0000;
        v.in_row1      = 32'h4000_0000;
        v.in_row2      = 32'h4040_0000;
        v.in_row3      = 32'h4080_0000;
        v.batch_end_in = 1'b1;
        send_vec(v);
    endtask

    // Zero, all-ones, max-float, negative-zero and min-subnormal matrices: Inf*0, Inf-Inf, overflow
    task automatic test_matrix_extremes();
        load_matrix_all(64'd0);
        send_fill(32'h7F80_0000, 32'h3F80_0000, 1'b1);
        send_fill(32'h8000_0000, 32'h8000_0000, 1'b0);
        load_matrix_all({2{32'h7F7F_FFFF}});
        send_fill(32'h7F7F_FFFF, 32'h3F80_0000, 1'b0);
        send_fill(32'h3F80_0000, 32'hBF80_0000, 1'b1);
        send_fill(32'h7F80_0000, 32'hFF80_0000, 1'b0);
        load_matrix_all({2{32'h8000_0000}});
        send_fill(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_fill(32'h0000_0000, 32'h0000_0000, 1'b1);
        load_matrix_all({2{32'h0000_0001}});
        send_fill(32'h3F00_0000, 32'h3FC0_0000, 1'b0);
        send_fill(32'h4B00_0000, 32'hCB00_0000, 1'b1);
        load_matrix_all(64'hFFFF_FFFF_FFFF_FFFF);
        send_fill(32'h3F80_0000, 32'h0000_0000, 1'b0);
        // Out-of-range indexes must leave the matrix alone
        write_reg(fmt_pkg::NUM_REGS, 64'd0);
        write_reg((1 << fmt_pkg::CFG_IDX_W) - 1, 64'h1234_5678_9ABC_DEF0);
        load_matrix_all({32'h3F80_0000, 32'hBF80_0000});
        send_fill(32'h4000_0000, 32'h4000_0000, 1'b0);
        send_rand_vec();
    endtask

    // Random matrices with random vectors, two quiet phases among them
    task automatic test_random_stream();
        for (int ph = 0; ph < 12; ph++) begin
            load_matrix_rand();
            stall_quiet = (ph == 3 || ph == 8);
            repeat (110) send_rand_vec();
        end
        stall_quiet = 1'b0;
    endtask

    // Output-side backpressure: mostly free, some short and a few long holds
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_quiet) begin
            i_out_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold > 0) begin
            i_out_stall <= 1'b1;
            stall_hold  <= stall_hold - 1;
        end else begin
            case ($urandom_range(0, 39))
                0: begin
                    i_out_stall <= 1'b1;
                    stall_hold  <= $urandom_range(8, 30);
                end
                1, 2, 3, 4, 5: begin
                    i_out_stall <= 1'b1;
                    stall_hold  <= $urandom_range(0, 2);
                end
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        fmt_pkg::t_vec_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", o_out_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.out_row0 !== want.out_row0) begin
                    $error("out_row0 expected %h actual %h", want.out_row0,
                           o_out_data.out_row0);
                    error_count++;
                end
                if (o_out_data.out_row1 !== want.out_row1) begin
                    $error("out_row1 expected %h actual %h", want.out_row1,
                           o_out_data.out_row1);
                    error_count++;
                end
                if (o_out_data.out_row2 !== want.out_row2) begin
                    $error("out_row2 expected %h actual %h", want.out_row2,
                           o_out_data.out_row2);
                    error_count++;
                end
                if (o_out_data.out_row3 !== want.out_row3) begin
                    $error("out_row3 expected %h actual %h", want.out_row3,
                           o_out_data.out_row3);
                    error_count++;
                end
                if (o_out_data.batch_end_out !== want.batch_end_out) begin
                    $error("batch_end_out expected %b actual %b", want.batch_end_out,
                           o_out_data.batch_end_out);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        error_count = 0;
        stall_quiet = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        matrix_regs[0] = fmt_pkg::ONE_LO;
        matrix_regs[1] = 64'd0;
        matrix_regs[2] = fmt_pkg::ONE_HI;
        matrix_regs[3] = 64'd0;
        matrix_regs[4] = 64'd0;
        matrix_regs[5] = fmt_pkg::ONE_LO;
        matrix_regs[6] = 64'd0;
        matrix_regs[7] = fmt_pkg::ONE_HI;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_extremes();
        test_matrix_extremes();
        test_random_stream();

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (fmt_pkg::PIPE_LAT + 5) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* fixed_matrix_transform_4x4_fp32_top.f */
sv/fmt_pkg.sv
sv/fmt_fmul.sv
sv/fmt_fadd.sv
sv/fixed_matrix_transform_4x4_fp32_top.sv
test/fixed_matrix_transform_4x4_fp32_top_test.sv
